// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL core. Every check is sampled on the
// rising edge of i_clk and is switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ptb_pkg.sv =====
package ptb_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int COUNT_BITS = 16;
    localparam int RESULT_CAP = 16;

    localparam int SLOT_BITS  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int ALLOC_BITS = $clog2(NUM_TIMERS + 1);
    localparam int CNT_BITS   = $clog2(RESULT_CAP + 1);
    localparam int CMP_BITS   = (ALLOC_BITS > 4) ? ALLOC_BITS : 4;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_CREATE  = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_CREATED = 2'd0,
        KIND_FULL    = 2'd1,
        KIND_FIRED   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CREATE,
        ST_RESTART,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] slot;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [COUNT_BITS-1:0] reload;
        logic [COUNT_BITS-1:0] remaining;
    } t_entry;

    // Slot numbers leave the block as four bits.
    function automatic logic [3:0] to_slot4(input logic [SLOT_BITS-1:0] idx);
        logic [SLOT_BITS+3:0] wide;
        wide = {4'b0000, idx};
        return wide[3:0];
    endfunction

    // Keep the low COUNT_BITS bits of the 16-bit period field.
    function automatic logic [COUNT_BITS-1:0] fit_count(input logic [15:0] p);
        logic [COUNT_BITS+15:0] wide;
        wide = {{COUNT_BITS{1'b0}}, p};
        return wide[COUNT_BITS-1:0];
    endfunction

endpackage

// ===== sv/ptb_out_reg.sv =====
// Output holding register: takes one result from the engine and presents it
// on the master side until the consumer takes it.
module ptb_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ptb_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_can_push,
    output logic             o_valid,
    output ptb_pkg::t_result o_result
);

    logic             r_valid;
    ptb_pkg::t_result r_result;

    assign o_can_push = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_push) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_push && i_push) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== sv/periodic_timer_bank_core.sv =====
// Channel   Direction  Ports                 Contents
// s_axis    in         tvalid/tready/tdata   tuser: command; tdata: period, target_slot
// m_axis    out        tvalid/tready/tdata   tuser: kind; tdata: slot; tlast: last
//
// One item is worked on at a time. Before the block accepts again, a create
// passes the create state, a restart of a created slot the restart state, a
// tick on a used bank the scan state over its slots and then the flush state;
// any other item stays in idle. One memory read port feeds an unstalled scan a
// slot per cycle. A stalled output holds the create, scan or flush in place.
// Reset clears the control state and slot count, not the timer memory.
`include "assert_macros.svh"

module periodic_timer_bank_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: [15:0] period, [19:16] target_slot, [23:20] zero
    input  logic [23:0] s_axis_tdata,
    // tuser: [1:0] command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: [3:0] slot, [7:4] zero
    output logic [7:0]  m_axis_tdata,
    // tuser: [1:0] kind
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    // Control and slot bookkeeping.
    ptb_pkg::t_state                  r_state, n_state;
    logic [ptb_pkg::ALLOC_BITS-1:0]   r_alloc, n_alloc;
    logic [ptb_pkg::SLOT_BITS-1:0]    r_idx, n_idx;
    logic [ptb_pkg::COUNT_BITS-1:0]   r_period, n_period;
    logic                             r_hold_valid, n_hold_valid;
    logic [ptb_pkg::SLOT_BITS-1:0]    r_hold_slot, n_hold_slot;
    logic [ptb_pkg::CNT_BITS-1:0]     r_fire_cnt, n_fire_cnt;

    // Timer memory: one word per slot with reload value and current count.
    ptb_pkg::t_entry                  r_mem [ptb_pkg::NUM_TIMERS];
    ptb_pkg::t_entry                  r_rdata;
    logic                             mem_we, mem_re;
    logic [ptb_pkg::SLOT_BITS-1:0]    mem_waddr, mem_raddr;
    ptb_pkg::t_entry                  mem_wdata;

    // Output path.
    logic                             push, can_push, out_valid;
    ptb_pkg::t_result                 push_result, out_result;

    ptb_pkg::t_cmd                    cmd;
    logic                             accept;
    logic                             bank_full, target_ok, fire, can_hold, need_push, stall;
    logic [ptb_pkg::ALLOC_BITS-1:0]   alloc_dec;
    logic [ptb_pkg::CMP_BITS-1:0]     target_ext, alloc_ext;

    assign cmd        = ptb_pkg::t_cmd'(s_axis_tuser);
    assign accept     = s_axis_tvalid && s_axis_tready;
    assign bank_full  = (r_alloc == ptb_pkg::ALLOC_BITS'(ptb_pkg::NUM_TIMERS));
    assign alloc_dec  = r_alloc - ptb_pkg::ALLOC_BITS'(1);
    assign target_ext = ptb_pkg::CMP_BITS'(s_axis_tdata[19:16]);
    assign alloc_ext  = ptb_pkg::CMP_BITS'(r_alloc);
    assign target_ok  = (target_ext < alloc_ext);

    // During the scan, r_rdata holds the word of slot r_idx.
    assign fire      = (r_rdata.remaining == '0);
    // A new fire is kept only while fewer than RESULT_CAP fires were kept.
    assign can_hold  = (r_fire_cnt < ptb_pkg::CNT_BITS'(ptb_pkg::RESULT_CAP));
    // A kept fire goes out as soon as a later one shows it was not the last.
    assign need_push = fire && can_hold && r_hold_valid;
    assign stall     = need_push && !can_push;

    assign s_axis_tready = (r_state == ptb_pkg::ST_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptb_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (cmd)
                        ptb_pkg::CMD_TICK: begin
                            if (r_alloc != '0) begin
                                n_state = ptb_pkg::ST_SCAN;
                            end
                        end
                        ptb_pkg::CMD_CREATE: begin
                            n_state = ptb_pkg::ST_CREATE;
                        end
                        ptb_pkg::CMD_RESTART: begin
                            if (target_ok) begin
                                n_state = ptb_pkg::ST_RESTART;
                            end
                        end
                        default: begin
                            n_state = ptb_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ptb_pkg::ST_CREATE: begin
                if (can_push) begin
                    n_state = ptb_pkg::ST_IDLE;
                end
            end
            ptb_pkg::ST_RESTART: begin
                n_state = ptb_pkg::ST_IDLE;
            end
            ptb_pkg::ST_SCAN: begin
                if (!stall && r_idx == '0) begin
                    n_state = ptb_pkg::ST_FLUSH;
                end
            end
            ptb_pkg::ST_FLUSH: begin
                if (!r_hold_valid || can_push) begin
                    n_state = ptb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ptb_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory access, result pushes and bookkeeping.
    always_comb begin
        n_alloc      = r_alloc;
        n_idx        = r_idx;
        n_period     = r_period;
        n_hold_valid = r_hold_valid;
        n_hold_slot  = r_hold_slot;
        n_fire_cnt   = r_fire_cnt;
        mem_we       = 1'b0;
        mem_waddr    = r_idx;
        mem_wdata    = r_rdata;
        mem_re       = 1'b0;
        mem_raddr    = r_idx;
        push         = 1'b0;
        push_result  = '{kind: ptb_pkg::KIND_FIRED, slot: ptb_pkg::to_slot4(r_hold_slot),
                         last: 1'b0};
        unique case (r_state)
            ptb_pkg::ST_IDLE: begin
                if (accept) begin
                    n_period = ptb_pkg::fit_count(s_axis_tdata[15:0]);
                    if (cmd == ptb_pkg::CMD_TICK) begin
                        // Start the scan at the newest slot.
                        n_idx        = alloc_dec[ptb_pkg::SLOT_BITS-1:0];
                        n_hold_valid = 1'b0;
                        n_fire_cnt   = '0;
                        mem_re       = (r_alloc != '0);
                        mem_raddr    = alloc_dec[ptb_pkg::SLOT_BITS-1:0];
                    end else if (cmd == ptb_pkg::CMD_RESTART) begin
                        n_idx     = target_ext[ptb_pkg::SLOT_BITS-1:0];
                        mem_re    = target_ok;
                        mem_raddr = target_ext[ptb_pkg::SLOT_BITS-1:0];
                    end
                end
            end
            ptb_pkg::ST_CREATE: begin
                push_result.slot = '0;
                push_result.last = 1'b1;
                push_result.kind = ptb_pkg::KIND_FULL;
                if (!bank_full) begin
                    push_result.kind = ptb_pkg::KIND_CREATED;
                    push_result.slot = ptb_pkg::to_slot4(r_alloc[ptb_pkg::SLOT_BITS-1:0]);
                end
                if (can_push) begin
                    push = 1'b1;
                    if (!bank_full) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_alloc[ptb_pkg::SLOT_BITS-1:0];
                        mem_wdata = '{reload: r_period, remaining: r_period};
                        n_alloc   = r_alloc + ptb_pkg::ALLOC_BITS'(1);
                    end
                end
            end
            ptb_pkg::ST_RESTART: begin
                mem_we    = 1'b1;
                mem_wdata = '{reload: r_rdata.reload, remaining: r_rdata.reload};
            end
            ptb_pkg::ST_SCAN: begin
                if (!stall) begin
                    mem_we = 1'b1;
                    if (fire) begin
                        mem_wdata.remaining = r_rdata.reload;
                    end else begin
                        mem_wdata.remaining = r_rdata.remaining
                                              - ptb_pkg::COUNT_BITS'(1);
                    end
                    push = need_push;
                    if (fire && can_hold) begin
                        n_hold_valid = 1'b1;
                        n_hold_slot  = r_idx;
                        n_fire_cnt   = r_fire_cnt + ptb_pkg::CNT_BITS'(1);
                    end
                    if (r_idx != '0) begin
                        n_idx     = r_idx - ptb_pkg::SLOT_BITS'(1);
                        mem_re    = 1'b1;
                        mem_raddr = r_idx - ptb_pkg::SLOT_BITS'(1);
                    end
                end
            end
            ptb_pkg::ST_FLUSH: begin
                // The fire still held is the last one of this tick.
                push_result.last = 1'b1;
                if (r_hold_valid && can_push) begin
                    push         = 1'b1;
                    n_hold_valid = 1'b0;
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ptb_pkg::ST_IDLE;
            r_alloc      <= '0;
            r_hold_valid <= 1'b0;
            r_fire_cnt   <= '0;
        end else begin
            r_state      <= n_state;
            r_alloc      <= n_alloc;
            r_hold_valid <= n_hold_valid;
            r_fire_cnt   <= n_fire_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_period    <= n_period;
        r_hold_slot <= n_hold_slot;
    end

    // Synchronous memory with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    ptb_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_result   (push_result),
        .i_ready    (m_axis_tready),
        .o_can_push (can_push),
        .o_valid    (out_valid),
        .o_result   (out_result)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {4'b0000, out_result.slot};
    assign m_axis_tuser  = out_result.kind;
    assign m_axis_tlast  = out_result.last;

    // The slot count never passes the size of the bank.
    `ASSERT_SAME(a_alloc_range, 1'b1,
        r_alloc <= ptb_pkg::ALLOC_BITS'(ptb_pkg::NUM_TIMERS),
        "slot count beyond bank size")
    // A scan step blocked by the output keeps its slot and its state.
    `ASSERT_NEXT(a_stall_holds, r_state == ptb_pkg::ST_SCAN && stall,
        r_state == ptb_pkg::ST_SCAN && $stable(r_idx),
        "stalled scan moved on")
    // Finishing slot zero always leads to the flush of the held fire.
    `ASSERT_NEXT(a_scan_ends, r_state == ptb_pkg::ST_SCAN && !stall && r_idx == '0,
        r_state == ptb_pkg::ST_FLUSH,
        "scan did not end after slot zero")
    // A held fire is always counted.
    `ASSERT_SAME(a_hold_counted, r_hold_valid, r_fire_cnt != '0,
        "held fire without count")

endmodule

// ===== tb/timer_bank_checker.sv =====
module timer_bank_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // tdata: [15:0] period, [19:16] target_slot, [23:20] zero
    input  logic [23:0] s_axis_tdata,
    // tuser: [1:0] command
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: [3:0] slot, [7:4] zero
    input  logic [7:0]  m_axis_tdata,
    // tuser: [1:0] kind
    input  logic [1:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_fired,
    output int          o_refused,
    output int          o_widest_tick
);

    localparam int REPORT_LIMIT = 10;

    typedef logic [ptb_pkg::COUNT_BITS-1:0] count_t;

    // Shadow copy of the bank: current counts, reload periods and slots in use.
    count_t           count_now [ptb_pkg::NUM_TIMERS];
    count_t           period_of [ptb_pkg::NUM_TIMERS];
    int               slots_used = 0;
    ptb_pkg::t_result due_events[$];

    initial begin
        o_mismatches  = 0;
        o_pending     = 0;
        o_fired       = 0;
        o_refused     = 0;
        o_widest_tick = 0;
    end

    // Works out the events one accepted command causes and queues them.
    task automatic advance_bank(input logic [1:0] cmd, input logic [15:0] period,
                                input logic [3:0] target);
        ptb_pkg::t_result ev;
        int               firing[$];
        int               i;
        case (cmd)
            ptb_pkg::CMD_TICK: begin
                // Highest slot first; a zero count fires and reloads.
                for (i = slots_used - 1; i >= 0; i--) begin
                    if (count_now[i] == '0) begin
                        count_now[i] = period_of[i];
                        if (firing.size() < ptb_pkg::RESULT_CAP) begin
                            firing.push_back(i);
                        end
                    end else begin
                        count_now[i] = count_now[i] - 1'b1;
                    end
                end
                for (i = 0; i < firing.size(); i++) begin
                    ev.kind = ptb_pkg::KIND_FIRED;
                    ev.slot = 4'(firing[i]);
                    ev.last = (i == firing.size() - 1);
                    due_events.push_back(ev);
                end
                if (firing.size() > o_widest_tick) begin
                    o_widest_tick = firing.size();
                end
            end
            ptb_pkg::CMD_CREATE: begin
                ev.last = 1'b1;
                if (slots_used >= ptb_pkg::NUM_TIMERS) begin
                    ev.kind = ptb_pkg::KIND_FULL;
                    ev.slot = 4'd0;
                end else begin
                    period_of[slots_used] = count_t'(period);
                    count_now[slots_used] = count_t'(period);
                    ev.kind = ptb_pkg::KIND_CREATED;
                    ev.slot = 4'(slots_used);
                    slots_used++;
                end
                due_events.push_back(ev);
            end
            ptb_pkg::CMD_RESTART: begin
                if (int'(target) < slots_used && int'(target) < ptb_pkg::NUM_TIMERS) begin
                    count_now[target] = period_of[target];
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic compare_event(input logic [1:0] kind, input logic [3:0] slot,
                                 input logic last);
        ptb_pkg::t_result want;
        if (kind == ptb_pkg::KIND_FIRED) begin
            o_fired++;
        end
        if (kind == ptb_pkg::KIND_FULL) begin
            o_refused++;
        end
        if (due_events.size() == 0) begin
            if (o_mismatches < REPORT_LIMIT) begin
                $display("[%0t] unexpected event: kind %0d slot %0d last %0d",
                         $realtime, kind, slot, last);
            end
            o_mismatches++;
        end else begin
            want = due_events.pop_front();
            if (kind !== want.kind || slot !== want.slot || last !== want.last) begin
                if (o_mismatches < REPORT_LIMIT) begin
                    $display("[%0t] event mismatch: expected kind %0d slot %0d last %0d",
                             $realtime, want.kind, want.slot, want.last);
                    $display("    got kind %0d slot %0d last %0d", kind, slot, last);
                end
                o_mismatches++;
            end
        end
    endtask

    // Results are handled before commands: a command accepted on the same edge
    // cannot already have produced the result that leaves on that edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                compare_event(m_axis_tuser, m_axis_tdata[3:0], m_axis_tlast);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                advance_bank(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[19:16]);
            end
        end
        o_pending = due_events.size();
    end

endmodule

// ===== tb/periodic_timer_bank_core_test.sv =====
module periodic_timer_bank_core_test;

    // The clock runs at a period of 12; reset is held low for the first cycles.
    localparam int CLK_HIGH      = 6;
    localparam int CLK_LOW       = 6;
    localparam int RESET_CYCLES  = 10;
    // A tick over a full bank is stretched by stalls on the result side; sender
    // gaps and receiver stalls are bounded by their random ranges.
    // The watchdog limit is many times the longest quiet stretch of a good run.
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 40;
    localparam int FIRST_RANDOM  = 130;
    localparam int SECOND_RANDOM = 140;

    // Command code 3 has no meaning; the block must drop it without a trace.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    // tdata: [15:0] period, [19:16] target_slot, [23:20] zero
    logic [23:0] s_axis_tdata   = '0;
    // tuser: [1:0] command
    logic [1:0]  s_axis_tuser   = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    // tdata: [3:0] slot, [7:4] zero
    logic [7:0]  m_axis_tdata;
    // tuser: [1:0] kind
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int mismatches;
    int events_due;
    int fire_events;
    int full_events;
    int widest_tick;

    // Tallies of what was sent, for the closing summary.
    int ticks_sent    = 0;
    int creates_sent  = 0;
    int restarts_sent = 0;
    int unused_sent   = 0;

    // When set, the sender presents items back to back with no gaps.
    logic steady_send = 1'b0;

    // Receiver state: how many more cycles the present ready level is held.
    int ready_left = 0;
    int ready_pick;

    int quiet_cycles = 0;

    periodic_timer_bank_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // The checker watches both channels on its own, keeps a shadow bank and
    // reports how many results went wrong and how many are still owed.
    timer_bank_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_mismatches  (mismatches),
        .o_pending     (events_due),
        .o_fired       (fire_events),
        .o_refused     (full_events),
        .o_widest_tick (widest_tick)
    );

    always begin
        #CLK_HIGH i_clk = 1'b1;
        #CLK_LOW  i_clk = 1'b0;
    end

    // Result side backpressure. Most stretches are short, some stalls are long,
    // and now and then ready stays high for a long run so results stream freely.
    always @(negedge i_clk) begin
        if (ready_left > 0) begin
            ready_left = ready_left - 1;
        end else begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 45) begin
                m_axis_tready <= 1'b1;
                ready_left = $urandom_range(0, 15);
            end else if (ready_pick < 85) begin
                m_axis_tready <= 1'b0;
                ready_left = $urandom_range(0, 3);
            end else if (ready_pick < 95) begin
                m_axis_tready <= 1'b0;
                ready_left = $urandom_range(10, 40);
            end else begin
                m_axis_tready <= 1'b1;
                ready_left = $urandom_range(80, 250);
            end
        end
    end

    // The watchdog counts cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles, %0d events still owed",
                     QUIET_LIMIT, events_due);
            $display("periodic_timer_bank_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Gap before the next item: mostly none or short, occasionally long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(15, 40);
    endfunction

    // Short periods keep timers firing often; a few long ones stay quiet.
    function automatic logic [15:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 16'($urandom_range(0, 3));
        end else if (r < 85) begin
            return 16'($urandom_range(4, 20));
        end else if (r < 95) begin
            return 16'($urandom_range(21, 200));
        end
        return 16'($urandom);
    endfunction

    // Presents one item at a falling edge and holds it until the block takes
    // it. Returns at the falling edge after acceptance, so the next item can
    // follow right away without valid dropping in between.
    task automatic send_item(input logic [1:0] cmd, input logic [15:0] period,
                             input logic [3:0] target);
        int gap;
        gap = steady_send ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser  = cmd;
        s_axis_tdata  = {4'b0000, target, period};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        case (cmd)
            ptb_pkg::CMD_TICK:    ticks_sent++;
            ptb_pkg::CMD_CREATE:  creates_sent++;
            ptb_pkg::CMD_RESTART: restarts_sent++;
            default:              unused_sent++;
        endcase
    endtask

    // One random item. Ticks dominate so timers keep firing; the create share
    // is a parameter so the bank fills early and stays full later.
    task automatic random_item(input int create_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < create_pct) begin
            send_item(ptb_pkg::CMD_CREATE, pick_period(), 4'($urandom));
        end else if (r < create_pct + 15) begin
            send_item(ptb_pkg::CMD_RESTART, 16'($urandom), 4'($urandom));
        end else if (r < create_pct + 19) begin
            send_item(CMD_UNUSED, 16'($urandom), 4'($urandom));
        end else begin
            send_item(ptb_pkg::CMD_TICK, 16'($urandom), 4'($urandom));
        end
    endtask

    initial begin
        int n;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed opening. The sender runs without gaps here so the exact
        // count evolution of the first slots is easy to follow.
        steady_send = 1'b1;
        // A tick on an empty bank walks nothing and returns nothing.
        send_item(ptb_pkg::CMD_TICK, 16'hFFFF, 4'hF);
        // A restart of a slot that was never created is dropped.
        send_item(ptb_pkg::CMD_RESTART, 16'h0000, 4'h0);
        // The unused command code changes nothing and returns nothing.
        send_item(CMD_UNUSED, 16'hFFFF, 4'hF);
        // Slot 0 with period zero fires on every tick.
        send_item(ptb_pkg::CMD_CREATE, 16'h0000, 4'h0);
        send_item(ptb_pkg::CMD_TICK, 16'h0000, 4'h0);
        // Slot 1 takes the largest period and never fires in this run.
        send_item(ptb_pkg::CMD_CREATE, 16'hFFFF, 4'hF);
        // Slot 2 fires every second tick, so some ticks fire two slots.
        send_item(ptb_pkg::CMD_CREATE, 16'h0001, 4'h0);
        send_item(ptb_pkg::CMD_TICK, 16'h0000, 4'h0);
        send_item(ptb_pkg::CMD_TICK, 16'h0000, 4'h0);
        // Reload slot 2, then try a slot that does not exist yet.
        send_item(ptb_pkg::CMD_RESTART, 16'h0000, 4'h2);
        send_item(ptb_pkg::CMD_RESTART, 16'hFFFF, 4'hF);
        send_item(ptb_pkg::CMD_TICK, 16'hFFFF, 4'hF);
        send_item(ptb_pkg::CMD_TICK, 16'h0000, 4'h0);
        // Reloading the slot with the largest period puts it back at the top.
        send_item(ptb_pkg::CMD_RESTART, 16'h0000, 4'h1);
        send_item(ptb_pkg::CMD_TICK, 16'h0000, 4'h0);
        send_item(CMD_UNUSED, 16'h0000, 4'h0);

        // First random stretch: the bank fills up gradually, so ticks walk
        // banks of every size along the way.
        for (n = 0; n < FIRST_RANDOM; n++) begin
            if (n % 40 == 0) begin
                steady_send = ($urandom_range(0, 3) == 0);
            end
            random_item(14);
        end

        // Hold the sender until every owed event has come back, so the block
        // is seen going fully idle in the middle of the run.
        s_axis_tvalid = 1'b0;
        while (events_due != 0) @(negedge i_clk);

        // Fill whatever slots remain until at least two creates have met a full bank.
        steady_send = 1'b0;
        while (creates_sent < ptb_pkg::NUM_TIMERS + 2) begin
            send_item(ptb_pkg::CMD_CREATE, pick_period(), 4'($urandom));
        end

        // Second random stretch on a full bank: mostly ticks and restarts, and
        // every create is refused.
        for (n = 0; n < SECOND_RANDOM; n++) begin
            if (n % 40 == 0) begin
                steady_send = ($urandom_range(0, 3) == 0);
            end
            random_item(5);
        end

        // Drain: wait until nothing is owed, then give any stray result time
        // to show up. The watchdog bounds the wait.
        s_axis_tvalid = 1'b0;
        while (events_due != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("covered %0d ticks, %0d creates (%0d full), %0d restarts, %0d unused",
                 ticks_sent, creates_sent, full_events, restarts_sent, unused_sent);
        $display("saw %0d fire events, at most %0d from a single tick; %0d mismatches",
                 fire_events, widest_tick, mismatches);
        if (mismatches == 0 && events_due == 0) begin
            $display("periodic_timer_bank_core verification clean");
        end else begin
            $display("periodic_timer_bank_core verification failed");
        end
        $finish;
    end

endmodule
